// ===== rtl/title_thread_grouper_unit_macros.svh =====
// Assertion macros shared by the title thread grouper RTL.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef TITLE_THREAD_GROUPER_UNIT_MACROS_SVH
`define TITLE_THREAD_GROUPER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define TTG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define TTG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TTG_ASSERT(lbl, clk, rst_n, prop, msg)
`define TTG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/ttg_pkg.sv =====
// Types and constants of the title thread grouper.
// No dependencies; used by ttg_intake, the top level and the testbench.
package ttg_pkg;

    localparam int ID_W = 16;
    localparam logic [ID_W-1:0] ID_MAX = 16'hFFFF;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam int PREFIX_LEN = 3;
    localparam int SKIP_LEN   = 4;

    typedef logic [3:0][7:0] t_lanes;

    typedef struct packed {
        logic [7:0] title_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0] post_id;
        logic [ID_W-1:0] group_id;
        logic            is_original;
        logic            table_full;
    } t_out_item;

    typedef struct packed {
        t_lanes head;
        t_lanes digest;
    } t_title_info;

    typedef struct packed {
        t_lanes          digest;
        logic [ID_W-1:0] thread;
    } t_meta;

endpackage

// ===== rtl/ttg_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ttg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/ttg_intake.sv =====
// Byte intake: collects title bytes into the staging RAM, tracks length,
// the first four bytes and the four-lane digest. Depends on ttg_pkg.
module ttg_intake #(
    parameter int TITLE_LEN = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  ttg_pkg::t_in_item              i_item,
    input  logic                           i_clear,
    output logic [$clog2(TITLE_LEN+1)-1:0] o_pos,
    output ttg_pkg::t_title_info           o_info,
    output logic                           o_wr_en,
    output logic [$clog2(TITLE_LEN)-1:0]   o_wr_addr,
    output logic [7:0]                     o_wr_data
);
    import ttg_pkg::*;

    localparam int PW = $clog2(TITLE_LEN + 1);
    localparam int KW = $clog2(TITLE_LEN);

    logic [PW-1:0] r_pos;
    logic          r_ended;
    t_lanes        r_head;
    t_lanes        r_dig;
    logic          take;

    // A byte is kept when the title is still open, nonzero and within length.
    assign take = i_accept && !r_ended && (i_item.title_byte != 8'd0)
                  && (r_pos < PW'(TITLE_LEN));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_pos   <= '0;
            r_ended <= 1'b0;
            r_head  <= '0;
            r_dig   <= '0;
        end else begin
            if (i_accept && !r_ended && (i_item.title_byte == 8'd0)) begin
                r_ended <= 1'b1;
            end
            if (take) begin
                r_pos <= r_pos + 1'b1;
                r_dig[r_pos[1:0]] <= r_dig[r_pos[1:0]] + i_item.title_byte;
                if (r_pos < PW'(SKIP_LEN)) begin
                    r_head[r_pos[1:0]] <= i_item.title_byte;
                end
            end
        end
    end

    assign o_pos       = r_pos;
    assign o_info      = '{head: r_head, digest: r_dig};
    assign o_wr_en     = take;
    assign o_wr_addr   = r_pos[KW-1:0];
    assign o_wr_data   = i_item.title_byte;
endmodule

// ===== rtl/title_thread_grouper_unit.sv =====
// Title thread grouper, top level: one byte of a title is taken per start
// pulse; the last byte triggers a newest-to-oldest search of the key table.
// Depends on ttg_pkg, ttg_intake, ttg_ram and the assertion macro header.
//
// Usage: every title byte is one item and is taken while busy is low. After
// the item that carries last_byte, busy stays high while the stored entries
// are searched, the key is written, and the result is shown for one cycle on
// o_result with o_done high. The receiver cannot stall: the result must be
// captured in that cycle. A compare stops at the first differing byte, a
// matching entry ends the search, and the key write is skipped once the
// table is full. Busy drops in the cycle after the result. Every step reads
// one memory entry with registered read data, so each visited entry, each
// compared byte and each stored byte takes a request state and a wait state.
// Reply titles start with "Re:" and lose up to their first four bytes from
// the key; the post id counts up from one and saturates at its maximum.
`include "title_thread_grouper_unit_macros.svh"

module title_thread_grouper_unit #(
    parameter int TITLE_LEN = 64,
    parameter int MAX_POSTS = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  ttg_pkg::t_in_item     i_item,
    output logic                  o_done,
    output ttg_pkg::t_out_item    o_result
);
    import ttg_pkg::*;

    localparam int KW = $clog2(TITLE_LEN);
    localparam int PW = $clog2(TITLE_LEN + 1);
    localparam int EW = $clog2(MAX_POSTS);
    localparam int CW = $clog2(MAX_POSTS + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SETUP = 4'd1;
    localparam logic [3:0] S_SRCH  = 4'd2;
    localparam logic [3:0] S_SRCHW = 4'd3;
    localparam logic [3:0] S_CMP   = 4'd4;
    localparam logic [3:0] S_CMPW  = 4'd5;
    localparam logic [3:0] S_STR   = 4'd6;
    localparam logic [3:0] S_STRW  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]      r_state;
    logic [CW-1:0]   r_count;
    logic [ID_W-1:0] r_next_id;
    logic [CW-1:0]   r_e;
    logic [KW-1:0]   r_k;
    logic [PW-1:0]   r_start;
    logic [PW-1:0]   r_klen;
    t_lanes          r_kdig;
    logic            r_reply;
    logic            r_full;
    logic [ID_W-1:0] r_thread;
    logic [ID_W-1:0] r_cand;

    logic            accept;
    logic [PW-1:0]   pos;
    t_title_info     info;
    logic            stg_we;
    logic [KW-1:0]   stg_waddr;
    logic [7:0]      stg_wdata;
    logic [7:0]      stg_rdata;
    logic [KW:0]     stg_sum;
    logic [7:0]      key_b;
    logic [7:0]      ks_rdata;
    logic            ks_we;
    logic [EW+KW-1:0] ks_raddr;
    logic [EW+KW-1:0] ks_waddr;
    logic            meta_we;
    logic [EW-1:0]   meta_raddr;
    t_meta           meta_wdata;
    t_meta           meta_rdata;
    logic            reply_c;
    logic [PW-1:0]   start_c;
    t_lanes          kdig_c;
    logic            last_k;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    ttg_intake #(.TITLE_LEN(TITLE_LEN)) u_intake (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_item    (i_item),
        .i_clear   (r_state == S_DONE),
        .o_pos     (pos),
        .o_info    (info),
        .o_wr_en   (stg_we),
        .o_wr_addr (stg_waddr),
        .o_wr_data (stg_wdata)
    );

    // Staging buffer holds the raw title bytes of the title in flight.
    ttg_ram #(.WIDTH(8), .DEPTH(2**KW)) u_stage (
        .i_clk   (i_clk),
        .i_we    (stg_we),
        .i_waddr (stg_waddr),
        .i_wdata (stg_wdata),
        .i_raddr (stg_sum[KW-1:0]),
        .o_rdata (stg_rdata)
    );

    // Key table: one row of 2**KW bytes per entry, zero padded.
    ttg_ram #(.WIDTH(8), .DEPTH(MAX_POSTS * (2**KW))) u_keys (
        .i_clk   (i_clk),
        .i_we    (ks_we),
        .i_waddr (ks_waddr),
        .i_wdata (key_b),
        .i_raddr (ks_raddr),
        .o_rdata (ks_rdata)
    );

    // Digest and thread id of each entry share one word.
    ttg_ram #(.WIDTH($bits(t_meta)), .DEPTH(MAX_POSTS)) u_meta (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (r_count[EW-1:0]),
        .i_wdata (meta_wdata),
        .i_raddr (meta_raddr),
        .o_rdata (meta_rdata)
    );

    // Reply detection and the key digest, taken from the intake registers.
    // Key byte k sits at title byte k+start; start is zero or four, save that a
    // reply under four bytes skips them all. Each title byte keeps its lane,
    // so the reply digest is the title digest minus the four dropped bytes.
    always_comb begin
        reply_c = (pos >= PW'(PREFIX_LEN)) && (info.head[0] == CH_R)
                  && (info.head[1] == CH_E) && (info.head[2] == CH_COLON);
        start_c = '0;
        kdig_c  = info.digest;
        if (reply_c) begin
            if (pos >= PW'(SKIP_LEN)) begin
                start_c = PW'(SKIP_LEN);
                for (int l = 0; l < 4; l++) begin
                    kdig_c[l] = info.digest[l] - info.head[l];
                end
            end else begin
                start_c = pos;
                kdig_c  = '0;
            end
        end
    end

    assign stg_sum    = {1'b0, r_k} + (KW+1)'(r_start);
    assign key_b      = (PW'(r_k) < r_klen) ? stg_rdata : 8'd0;
    assign ks_raddr   = {r_e[EW-1:0], r_k};
    assign ks_waddr   = {r_count[EW-1:0], r_k};
    assign ks_we      = (r_state == S_STRW);
    assign last_k     = (r_k == KW'(TITLE_LEN - 1));
    assign meta_we    = (r_state == S_STRW) && last_k;
    assign meta_wdata = '{digest: r_kdig, thread: r_thread};
    assign meta_raddr = EW'(r_e - 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_next_id <= ID_W'(1);
            r_e       <= '0;
            r_k       <= '0;
            r_reply   <= 1'b0;
            r_full    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept && i_item.last_byte) begin
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_reply  <= reply_c;
                    r_start  <= start_c;
                    r_klen   <= pos - start_c;
                    r_kdig   <= kdig_c;
                    r_thread <= r_next_id;
                    r_full   <= 1'b0;
                    r_e      <= r_count;
                    r_state  <= S_SRCH;
                end
                S_SRCH: begin
                    if (r_e == '0) begin
                        r_k     <= '0;
                        r_state <= S_STR;
                    end else begin
                        r_e     <= r_e - 1'b1;
                        r_state <= S_SRCHW;
                    end
                end
                S_SRCHW: begin
                    r_cand <= meta_rdata.thread;
                    r_k    <= '0;
                    if (meta_rdata.digest == r_kdig) begin
                        r_state <= S_CMP;
                    end else begin
                        r_state <= S_SRCH;
                    end
                end
                S_CMP: begin
                    r_state <= S_CMPW;
                end
                S_CMPW: begin
                    if (ks_rdata != key_b) begin
                        r_state <= S_SRCH;
                    end else if (last_k) begin
                        r_thread <= r_cand;
                        r_k      <= '0;
                        r_state  <= S_STR;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_CMP;
                    end
                end
                S_STR: begin
                    if (r_count >= CW'(MAX_POSTS)) begin
                        r_full  <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_STRW;
                    end
                end
                S_STRW: begin
                    if (last_k) begin
                        r_count <= r_count + 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_STR;
                    end
                end
                S_DONE: begin
                    if (r_next_id != ID_MAX) begin
                        r_next_id <= r_next_id + 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done = (r_state == S_DONE);
    assign o_result = '{post_id: r_next_id, group_id: r_thread,
                        is_original: !r_reply, table_full: r_full};

    // A result only appears while the block is busy, and frees it next cycle.
    `TTG_ASSERT(a_done_busy, i_clk, i_rst_n, o_done |-> busy, "result outside busy phase")
    `TTG_ASSERT_NEXT(a_done_free, i_clk, i_rst_n, o_done, !busy, "block stays busy after result")
    // The block only goes busy after accepting a final byte.
    `TTG_ASSERT(a_busy_cause, i_clk, i_rst_n, $rose(busy) |-> $past(accept && i_item.last_byte), "busy without final byte")
    // The fill count never passes the table size.
    `TTG_ASSERT(a_count_max, i_clk, i_rst_n, r_count <= CW'(MAX_POSTS), "entry count overflow")
    // Thread ids never exceed the post id handed out with them.
    `TTG_ASSERT(a_thread_le, i_clk, i_rst_n, o_done |-> (o_result.group_id <= o_result.post_id), "thread id above post id")
endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench of title_thread_grouper_unit: title bytes are driven
// as items, results are predicted and checked field by field.
// Depends on ttg_pkg and the RTL of the title thread grouper.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ttg_pkg::*;

    localparam int TITLE_LEN  = 64;
    localparam int MAX_POSTS  = 1024;
    localparam int CYCLE_CAP  = 40000000;
    localparam int RAND_BYTES = 1020;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_item;
    logic      o_done;
    t_out_item o_result;

    title_thread_grouper_unit #(
        .TITLE_LEN(TITLE_LEN),
        .MAX_POSTS(MAX_POSTS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_item(i_item),
        .o_done(o_done),
        .o_result(o_result)
    );

    // Clock with a 4 ns period.
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Items waiting to be driven, and results waiting to be seen.
    t_in_item  byte_queue[$];
    t_out_item expected_ids[$];
    int        n_titles;
    int        n_total;
    int        n_sent;
    int        n_errors;
    longint    n_cycles;

    // Predictor state: the key table and the title under assembly.
    logic [TITLE_LEN-1:0][7:0] key_tab[MAX_POSTS];
    t_lanes                    digest_tab[MAX_POSTS];
    logic [ID_W-1:0]           thread_tab[MAX_POSTS];
    int                        fill_count;
    logic [ID_W-1:0]           next_post;
    logic [TITLE_LEN-1:0][7:0] title_buf;
    int                        title_pos;
    logic                      title_ended;

    // Takes one accepted byte; on the last byte, works out the ids that the
    // block must return and updates the key table the way the block does.
    task automatic group_title(input t_in_item it);
        logic [TITLE_LEN-1:0][7:0] key;
        t_lanes                    dig;
        logic                      reply;
        int                        skip;
        t_out_item                 res;
        if (!title_ended) begin
            if (it.title_byte == 8'h00) begin
                title_ended = 1'b1;
            end else if (title_pos < TITLE_LEN) begin
                title_buf[title_pos] = it.title_byte;
                title_pos++;
            end
        end
        if (!it.last_byte) return;
        reply = title_pos >= PREFIX_LEN && title_buf[0] == CH_R &&
                title_buf[1] == CH_E && title_buf[2] == CH_COLON;
        skip = 0;
        if (reply) skip = (title_pos >= SKIP_LEN) ? SKIP_LEN : title_pos;
        key = '0;
        dig = '0;
        for (int i = skip; i < title_pos; i++) begin
            dig[(i - skip) % 4] = dig[(i - skip) % 4] + title_buf[i];
            key[i - skip] = title_buf[i];
        end
        res.post_id = next_post;
        res.group_id = next_post;
        // The newest entry with an equal key decides the thread.
        for (int j = fill_count - 1; j >= 0; j--) begin
            if (digest_tab[j] == dig && key_tab[j] == key) begin
                res.group_id = thread_tab[j];
                break;
            end
        end
        res.is_original = !reply;
        res.table_full = (fill_count >= MAX_POSTS);
        if (!res.table_full) begin
            key_tab[fill_count] = key;
            digest_tab[fill_count] = dig;
            thread_tab[fill_count] = res.group_id;
            fill_count++;
        end
        if (next_post != ID_MAX) next_post++;
        expected_ids.push_back(res);
        title_buf = '0;
        title_pos = 0;
        title_ended = 1'b0;
    endtask

    // Queues one title as a run of items, the last one flagged.
    task automatic queue_title(input logic [7:0] bytes[$]);
        t_in_item it;
        foreach (bytes[i]) begin
            it.title_byte = bytes[i];
            it.last_byte = (i == bytes.size() - 1);
            byte_queue.push_back(it);
        end
        n_titles++;
    endtask

    // Builds a title from a small pool of subjects, so that replies and
    // repeats land on keys that are already stored.
    task automatic queue_random_title();
        logic [7:0] bytes[$];
        int         kind;
        int         len;
        int         subj;
        kind = $urandom_range(0, 99);
        subj = $urandom_range(0, 11);
        if (kind < 60) begin
            // Well-formed: optional reply prefix, then a pooled subject.
            if ($urandom_range(0, 1)) begin
                bytes.push_back(CH_R);
                bytes.push_back(CH_E);
                bytes.push_back(CH_COLON);
                bytes.push_back($urandom_range(0, 1) ? 8'h20 : 8'($urandom_range(1, 255)));
            end
            len = 1 + subj % 6;
            for (int i = 0; i < len; i++) bytes.push_back(8'h41 + 8'(subj * 3 + i));
            if ($urandom_range(0, 9) == 0) begin
                // A NUL followed by trailing bytes that must be ignored.
                bytes.push_back(8'h00);
                bytes.push_back(8'($urandom_range(0, 255)));
            end
        end else if (kind < 70) begin
            // Short reply prefixes and partial prefixes.
            bytes.push_back(CH_R);
            if ($urandom_range(0, 3) != 0) bytes.push_back(CH_E);
            if ($urandom_range(0, 3) != 0) bytes.push_back(CH_COLON);
        end else if (kind < 73) begin
            // Titles near or past the length limit; the block truncates the overlong ones.
            len = $urandom_range(TITLE_LEN - 2, TITLE_LEN + 8);
            for (int i = 0; i < len; i++) bytes.push_back(8'($urandom_range(1, 255)));
        end else begin
            // Noise of random bytes, NUL included.
            len = $urandom_range(1, 10);
            for (int i = 0; i < len; i++) bytes.push_back(8'($urandom_range(0, 255)));
        end
        queue_title(bytes);
    endtask

    // Stimulus: directed titles, random titles, then enough one-byte titles
    // to fill the key table and run past it.
    initial begin
        logic [7:0] b[$];
        n_titles = 0;
        b = '{8'hFF};                              queue_title(b);
        b = '{8'h01};                              queue_title(b);
        b = '{8'h00};                              queue_title(b);
        b = '{CH_R, CH_E, CH_COLON};               queue_title(b);
        b = '{CH_R, CH_E, CH_COLON, 8'h20, 8'hFF}; queue_title(b);
        b = '{CH_R, CH_E, CH_COLON, 8'h00, 8'h7E}; queue_title(b);
        b = '{8'h80, 8'h00, 8'h55};                queue_title(b);
        b = '{8'h7F, 8'h80};                       queue_title(b);
        b = '{CH_R, CH_E, CH_COLON, 8'h33, 8'h7F, 8'h80}; queue_title(b);
        while (byte_queue.size() < RAND_BYTES) queue_random_title();
        while (n_titles < MAX_POSTS + 40) begin
            b = '{8'($urandom_range(0, 255))};
            queue_title(b);
        end
        n_total = byte_queue.size();
    end

    // Driver: the sender idles on 32 percent of its draws for the first third
    // of the items, on 56 percent for the second third, and never for the rest.
    always @(posedge i_clk) begin
        int       idle_pct;
        logic     go;
        t_in_item nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
            i_item <= '0;
        end else begin
            if (start && !busy) begin
                group_title(i_item);
                n_sent++;
            end
            if (!start || !busy) begin
                idle_pct = (n_sent < n_total / 3) ? 32 :
                           (n_sent < 2 * n_total / 3) ? 56 : 0;
                go = byte_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct;
                if (go) begin
                    nxt = byte_queue.pop_front();
                    i_item <= nxt;
                end
                start <= go;
            end
        end
    end

    // Monitor: every strobed result is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_done) begin
            if (expected_ids.size() == 0) begin
                $display("%0t: unexpected result %p", $time, o_result);
                n_errors++;
            end else begin
                want = expected_ids.pop_front();
                if (o_result.post_id !== want.post_id ||
                    o_result.group_id !== want.group_id ||
                    o_result.is_original !== want.is_original ||
                    o_result.table_full !== want.table_full) begin
                    $display("%0t: mismatch expected %p actual %p",
                             $time, want, o_result);
                    n_errors++;
                end
            end
        end
    end

    // Cycle counter that ends a run that hangs.
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_CAP) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        n_sent = 0;
        n_errors = 0;
        n_cycles = 0;
        fill_count = 0;
        next_post = 1;
        title_buf = '0;
        title_pos = 0;
        title_ended = 1'b0;
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Wait until every item is taken and every result is back.
        wait (n_total > 0 && n_sent == n_total && expected_ids.size() == 0);
        repeat (300) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// ===== title_thread_grouper_unit.f =====
+incdir+rtl
rtl/ttg_pkg.sv
rtl/ttg_ram.sv
rtl/ttg_intake.sv
rtl/title_thread_grouper_unit.sv
dv/testbench.sv
